>>> hdl/shared_buffer_multi_stack_core_assert.svh
// Assertion macros shared by the multi-stack RTL.
// No dependencies; included by sbms_dpath, which carries concurrent checks.
`ifndef SHARED_BUFFER_MULTI_STACK_CORE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_STACK_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SBMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbms check failed");

// Next-cycle implication, disabled in reset.
`define SBMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbms check failed");

`endif

>>> hdl/sbms_pkg.sv
// Shared types and sizing constants for the multi-stack core.
// No dependencies.
package sbms_pkg;

  localparam int NUM_STACKS = 4;
  localparam int CAPACITY   = 16;
  localparam int DATA_W     = 32;
  localparam int SID_W      = 3;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int STK_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Slot pointer; valid clear means null.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } ptr_t;

  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // update lists and load the result register
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not draining
  } stat_t;

endpackage

>>> hdl/sbms_ctrl.sv
// Sequencer for the multi-stack core: request capture, then execute.
// Depends on sbms_pkg.
module sbms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  sbms_pkg::stat_t   stat,
  output logic              s_tready,
  output sbms_pkg::cmd_t    cmd
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= ST_EXEC;
            s_tready <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (!stat.out_busy) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  assign cmd.load = s_tvalid && s_tready;
  assign cmd.exec = (state == ST_EXEC) && !stat.out_busy;

endmodule

>>> hdl/sbms_dpath.sv
// Datapath: request register, list heads, link store, data memory, result register.
// Depends on sbms_pkg and shared_buffer_multi_stack_core_assert.svh.
`include "shared_buffer_multi_stack_core_assert.svh"

module sbms_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  sbms_pkg::cmd_t              cmd,
  input  logic                        in_action,
  input  logic [sbms_pkg::SID_W-1:0]  in_stack_id,
  input  logic [sbms_pkg::DATA_W-1:0] in_value,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic                        out_ok,
  output logic [sbms_pkg::DATA_W-1:0] out_popped_value,
  output sbms_pkg::stat_t             stat
);

  // Captured request
  logic                        req_action;
  logic [sbms_pkg::SID_W-1:0]  req_sid;
  logic [sbms_pkg::DATA_W-1:0] req_value;

  // List state
  sbms_pkg::ptr_t free_head;
  sbms_pkg::ptr_t stack_head [sbms_pkg::NUM_STACKS];
  sbms_pkg::ptr_t link_store [sbms_pkg::CAPACITY];
  logic [sbms_pkg::DATA_W-1:0] data_mem [sbms_pkg::CAPACITY];

  logic                        sid_ok;
  logic [sbms_pkg::STK_W-1:0]  sel;
  sbms_pkg::ptr_t              top;
  logic                        push_ok;
  logic                        pop_ok;
  logic [sbms_pkg::IDX_W-1:0]  slot;
  sbms_pkg::ptr_t              slot_link;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= in_action;
      req_sid    <= in_stack_id;
      req_value  <= in_value;
    end
  end

  assign sid_ok = (req_sid != '0) && (32'(req_sid) <= 32'(sbms_pkg::NUM_STACKS));
  assign sel    = sbms_pkg::STK_W'(req_sid - sbms_pkg::SID_W'(1));
  assign top    = stack_head[sel];

  assign push_ok   = sid_ok && (req_action == sbms_pkg::ACT_PUSH) && free_head.valid;
  assign pop_ok    = sid_ok && (req_action == sbms_pkg::ACT_POP) && top.valid;
  assign slot      = (req_action == sbms_pkg::ACT_POP) ? top.idx : free_head.idx;
  assign slot_link = link_store[slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head.valid <= 1'b1;
      free_head.idx   <= '0;
      for (int i = 0; i < sbms_pkg::NUM_STACKS; i++) begin
        stack_head[i] <= '0;
      end
      for (int i = 0; i < sbms_pkg::CAPACITY; i++) begin
        link_store[i].idx   <= sbms_pkg::IDX_W'(i + 1);
        link_store[i].valid <= (i + 1) < sbms_pkg::CAPACITY;
      end
    end else if (cmd.exec) begin
      if (push_ok) begin
        free_head        <= slot_link;
        link_store[slot] <= top;
        stack_head[sel]  <= '{valid: 1'b1, idx: slot};
      end else if (pop_ok) begin
        stack_head[sel]  <= slot_link;
        link_store[slot] <= free_head;
        free_head        <= '{valid: 1'b1, idx: slot};
      end
    end
  end

  // Data memory: per execute, at most one write (push) or one registered read (pop).
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      data_mem[slot] <= req_value;
    end
    if (cmd.exec) begin
      out_ok <= push_ok || pop_ok;
      if (pop_ok) begin
        out_popped_value <= data_mem[slot];
      end else begin
        out_popped_value <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign stat.out_busy = m_tvalid && !m_tready;

  `SBMS_ASSERT_NOW(a_exec_no_overwrite, clk, rst, cmd.exec, !(m_tvalid && !m_tready))
  `SBMS_ASSERT_NEXT(a_exec_gives_word, clk, rst, cmd.exec, m_tvalid)
  `SBMS_ASSERT_NEXT(a_pop_frees_slot, clk, rst, cmd.exec && pop_ok, free_head.valid)

endmodule

>>> hdl/shared_buffer_multi_stack_core.sv
// A request word is captured in the request register; EXEC then commits it and loads the
// result register. A stalled result holds the core in execute until it drains.
// The core takes no new request word until the last one has executed.
// Reset (rst, synchronous, high): all stacks empty, free list 0 -> 1 -> ... -> last.
// Data slots are unknown after reset; only slots written by a push are ever read.
// Depends on sbms_pkg, sbms_ctrl and sbms_dpath.
module shared_buffer_multi_stack_core (
  input  logic        clk,
  input  logic        rst,
  // request word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [3:0]  s_tuser,   // [0] action (0 push, 1 pop), [3:1] stack_id
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] popped_value
  output logic [0:0]  m_tuser    // [0] ok
);

  sbms_pkg::cmd_t  cmd;
  sbms_pkg::stat_t stat;
  logic            ok;

  // Controller: IDLE takes a word, EXEC commits it once the result register
  // is free (empty, or being taken this cycle).
  sbms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // Datapath: the free list and every stack are linked through one link
  // store; push takes the free head, pop returns the top slot to it. The
  // data read of a pop lands straight in the result register.
  sbms_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .in_action        (s_tuser[0]),
    .in_stack_id      (s_tuser[3:1]),
    .in_value         (s_tdata),
    .m_tready         (m_tready),
    .m_tvalid         (m_tvalid),
    .out_ok           (ok),
    .out_popped_value (m_tdata),
    .stat             (stat)
  );

  assign m_tuser[0] = ok;

endmodule

>>> test/shared_buffer_multi_stack_checker.sv
// Passive checker for the multi-stack core: watches both stream channels and
// predicts every result word from its own copy of the stacks and the free list.
// Depends on sbms_pkg.
module shared_buffer_multi_stack_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [31:0]         s_tdata,   // [31:0] value
  input  logic [3:0]          s_tuser,   // [0] action, [3:1] stack_id
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [31:0]         m_tdata,   // [31:0] popped_value
  input  logic [0:0]          m_tuser,   // [0] ok
  output int unsigned         mismatches,
  output int unsigned         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        ok;
    logic [sbms_pkg::DATA_W-1:0] popped_value;
  } op_result_t;

  op_result_t                  expected_q[$];
  logic [sbms_pkg::DATA_W-1:0] slot_data [sbms_pkg::CAPACITY];
  sbms_pkg::ptr_t              slot_link [sbms_pkg::CAPACITY];
  sbms_pkg::ptr_t              stack_top [sbms_pkg::NUM_STACKS];
  sbms_pkg::ptr_t              free_top;

  // Apply one request to the shadow lists and return the word the core owes.
  function automatic op_result_t run_stack_op(logic act, logic [sbms_pkg::SID_W-1:0] sid,
                                              logic [sbms_pkg::DATA_W-1:0] val);
    op_result_t                 res;
    int unsigned                stk;
    logic [sbms_pkg::IDX_W-1:0] slot;
    res = '0;
    if (sid >= 1 && sid <= sbms_pkg::NUM_STACKS) begin
      stk = 32'(sid) - 32'd1;
      if (act == sbms_pkg::ACT_PUSH) begin
        if (free_top.valid) begin
          slot            = free_top.idx;
          slot_data[slot] = val;
          free_top        = slot_link[slot];
          slot_link[slot] = stack_top[stk];
          stack_top[stk]  = '{valid: 1'b1, idx: slot};
          res.ok          = 1'b1;
        end
      end else if (stack_top[stk].valid) begin
        slot             = stack_top[stk].idx;
        stack_top[stk]   = slot_link[slot];
        slot_link[slot]  = free_top;
        free_top         = '{valid: 1'b1, idx: slot};
        res.ok           = 1'b1;
        res.popped_value = slot_data[slot];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    op_result_t want;
    op_result_t got;
    if (rst) begin
      for (int i = 0; i < sbms_pkg::CAPACITY; i++) begin
        slot_data[i] = '0;
        slot_link[i] = '{valid: (i + 1 < sbms_pkg::CAPACITY),
                         idx: sbms_pkg::IDX_W'(i + 1)};
      end
      for (int i = 0; i < sbms_pkg::NUM_STACKS; i++) begin
        stack_top[i] = '0;
      end
      free_top   = '{valid: 1'b1, idx: '0};
      mismatches = 0;
      expected_q.delete();
    end else begin
      // result side first, so a stray word can never match a request of this edge
      if (m_tvalid && m_tready) begin
        got.ok           = m_tuser[0];
        got.popped_value = m_tdata;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: expected none, actual ok=%0b popped_value=%h",
                   $time, got.ok, got.popped_value);
        end else begin
          want = expected_q.pop_front();
          if (got.ok !== want.ok) begin
            mismatches++;
            $display("%0t: ok mismatch: expected %0b, actual %0b", $time,
                     want.ok, got.ok);
          end
          if (got.popped_value !== want.popped_value) begin
            mismatches++;
            $display("%0t: popped_value mismatch: expected %h, actual %h", $time,
                     want.popped_value, got.popped_value);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_q.push_back(run_stack_op(s_tuser[0], s_tuser[3:1], s_tdata));
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

>>> test/shared_buffer_multi_stack_core_tb.sv
// Top of the multi-stack core testbench: clock, reset, request and result drivers.
// Checking lives in shared_buffer_multi_stack_checker; depends on sbms_pkg and the core.
module shared_buffer_multi_stack_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_OPS   = 1300;    // in-range random requests
  localparam int unsigned CALM_TAIL    = 200;     // last requests run with no idling
  localparam int unsigned PRESSURE_OPS = 40;      // offered while results are held off
  localparam int unsigned HOLD_CYCLES  = 300;     // long result stall
  localparam int unsigned DRAIN_CYCLES = 10;      // settle time after the last result
  localparam int unsigned CYCLE_LIMIT  = 400000;  // watchdog limit for the whole run

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;     // [31:0] value
  logic [3:0]  s_tuser  = '0;     // [0] action, [3:1] stack_id
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] popped_value
  logic [0:0]  m_tuser;           // [0] ok

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // Knobs shared between the request and result processes.
  bit tx_gaps   = 1'b1;   // request side may idle
  bit rx_quiet  = 1'b0;   // result side never stalls
  bit hold_req  = 1'b0;   // ask the result side for one long stall

  always #6 clk = ~clk;

  shared_buffer_multi_stack_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  shared_buffer_multi_stack_checker stack_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offer one request word, optionally after an idle burst, and return at the
  // edge where it is taken. Inputs only move at negedge.
  task automatic send_word(input logic act, input logic [sbms_pkg::SID_W-1:0] sid,
                           input logic [sbms_pkg::DATA_W-1:0] val);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;      // garbage on an idle bus must be ignored
      s_tuser  <= 4'($urandom);
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= {sid, act};
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
  endtask

  // Result side: random stall bursts, calm stretches, and the long hold-off.
  initial begin : result_side
    int unsigned stall_pct;
    int unsigned window;
    stall_pct = 10;
    window    = 0;
    forever begin
      @(negedge clk);
      // re-pick the stall density every 128 decisions so some stretches never stall
      if (++window == 128) begin
        window = 0;
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      if (hold_req) begin
        // long hold-off: the core's single result slot fills and s_tready drops
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Request side: directed words, a back-pressure phase, then random traffic.
  initial begin : request_side
    int unsigned                 counted;
    int unsigned                 batch_left;
    int unsigned                 push_pct;
    int unsigned                 focus_sid;
    logic                        act;
    logic [sbms_pkg::SID_W-1:0]  sid;
    logic [sbms_pkg::DATA_W-1:0] val;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // -- directed: empty pops, out-of-range stack numbers, extremes, full store
    send_word(sbms_pkg::ACT_POP,  3'd1, $urandom);        // pop of an empty stack
    send_word(sbms_pkg::ACT_POP,  3'd0, $urandom);        // stack 0 does not exist
    send_word(sbms_pkg::ACT_PUSH, 3'd0, 32'h1234_5678);   // ignored, no slot used
    send_word(sbms_pkg::ACT_PUSH, 3'd5, 32'hdead_beef);   // above the last stack
    send_word(sbms_pkg::ACT_PUSH, 3'd7, 32'hffff_ffff);
    send_word(sbms_pkg::ACT_POP,  3'd6, $urandom);
    send_word(sbms_pkg::ACT_PUSH, 3'd1, 32'h8000_0000);
    send_word(sbms_pkg::ACT_PUSH, 3'd4, 32'h7fff_ffff);
    send_word(sbms_pkg::ACT_PUSH, 3'd2, 32'h0000_0000);
    send_word(sbms_pkg::ACT_PUSH, 3'd3, 32'hffff_ffff);
    // use up the remaining twelve slots, spread over all stacks
    for (int i = 0; i < sbms_pkg::CAPACITY - 4; i++) begin
      send_word(sbms_pkg::ACT_PUSH, sbms_pkg::SID_W'(i % sbms_pkg::NUM_STACKS + 1), $urandom);
    end
    send_word(sbms_pkg::ACT_PUSH, 3'd2, 32'h5555_aaaa);   // store full, refused
    send_word(sbms_pkg::ACT_POP,  3'd4, $urandom);
    send_word(sbms_pkg::ACT_POP,  3'd1, $urandom);

    // -- back-pressure: results held off while requests keep coming
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < PRESSURE_OPS; i++) begin
      send_word(($urandom_range(0, 1) == 0) ? sbms_pkg::ACT_PUSH : sbms_pkg::ACT_POP,
                sbms_pkg::SID_W'($urandom_range(1, sbms_pkg::NUM_STACKS)), $urandom);
    end

    // -- random: batches that lean toward filling or draining, with one
    //    favored stack, so the store swings between empty and full
    counted    = 0;
    batch_left = 0;
    push_pct   = 50;
    focus_sid  = 1;
    while (counted < RANDOM_OPS) begin
      if (batch_left == 0) begin
        batch_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 75;
        endcase
        focus_sid = $urandom_range(1, sbms_pkg::NUM_STACKS);
        tx_gaps   = ($urandom_range(0, 3) != 0);
      end
      batch_left--;
      // calm tail: neither side idles
      if (counted >= RANDOM_OPS - CALM_TAIL) begin
        tx_gaps  = 1'b0;
        rx_quiet = 1'b1;
      end

      act = ($urandom_range(0, 99) < push_pct) ? sbms_pkg::ACT_PUSH : sbms_pkg::ACT_POP;
      if ($urandom_range(0, 19) == 0) begin
        // noise: stack numbers 0, 5, 6, 7 are ignored and do not count
        sid = sbms_pkg::SID_W'($urandom_range(0, 3));
        if (sid != 0) sid = sid + sbms_pkg::SID_W'(4);
      end else begin
        sid = ($urandom_range(0, 1) == 0) ?
              sbms_pkg::SID_W'(focus_sid) :
              sbms_pkg::SID_W'($urandom_range(1, sbms_pkg::NUM_STACKS));
        counted++;
      end
      case ($urandom_range(0, 7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = 32'h0000_0000;
        3:       val = 32'hffff_ffff;
        default: val = $urandom;
      endcase
      send_word(act, sid, val);
    end

    // -- drain: wait for every owed word, then a few quiet cycles
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

>>> files.f
+incdir+hdl
hdl/sbms_pkg.sv
hdl/sbms_ctrl.sv
hdl/sbms_dpath.sv
hdl/shared_buffer_multi_stack_core.sv
test/shared_buffer_multi_stack_checker.sv
test/shared_buffer_multi_stack_core_tb.sv
